@@ rtl/trrc_pkg.sv @@
`default_nettype none
package trrc_pkg;

  localparam int unsigned PeriodW = 10;
  localparam int unsigned DurW    = 16;
  localparam int unsigned AmpW    = 16;
  localparam int unsigned IdW     = 4;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [1:0] RegRefresh = 2'd0;
  localparam logic [1:0] RegDefault = 2'd1;
  localparam logic [1:0] RegMax     = 2'd2;

  localparam logic [PeriodW-1:0] RefreshReset = PeriodW'(40);
  localparam logic [DurW-1:0]    DefaultReset = DurW'(1000);
  localparam logic [DurW-1:0]    MaxReset     = DurW'(60000);

  localparam logic KindTick    = 1'b0;
  localparam logic KindCommand = 1'b1;

  typedef logic [AmpW-1:0]           amp_t;
  typedef logic [DurW-1:0]           dur_t;
  typedef logic [PeriodW-1:0]        period_t;
  typedef logic signed [LevelW-1:0]  level_t;
  typedef logic [IdW-1:0]            id_t;

endpackage
`default_nettype wire

@@ rtl/trrc_in_if.sv @@
`default_nettype none
interface trrc_in_if
  import trrc_pkg::*;
();
  logic   valid;
  logic   ready;
  logic   kind;
  id_t    ctrl_id;
  level_t left_level;
  level_t right_level;
  dur_t   rumble_ms;

  modport source (output valid, output kind, output ctrl_id, output left_level,
                  output right_level, output rumble_ms, input ready);
  modport sink (input valid, input kind, input ctrl_id, input left_level,
                input right_level, input rumble_ms, output ready);
endinterface
`default_nettype wire

@@ rtl/trrc_out_if.sv @@
`default_nettype none
interface trrc_out_if
  import trrc_pkg::*;
();
  logic valid;
  logic ready;
  logic report_sent;
  amp_t low_amplitude;
  amp_t high_amplitude;
  logic command_accepted;

  modport source (output valid, output report_sent, output low_amplitude,
                  output high_amplitude, output command_accepted, input ready);
  modport sink (input valid, input report_sent, input low_amplitude,
                input high_amplitude, input command_accepted, output ready);
endinterface
`default_nettype wire

@@ rtl/timed_rumble_refresh_controller.sv @@
`default_nettype none
// Timed two-motor rumble controller. Each input item is a 1 ms tick or a rumble
// command and produces exactly one result item. An item is taken in every cycle in
// which the output register is empty or its result is being taken, so the block
// sustains one item per clock while results are taken; a result appears in the
// output register in the cycle after its item is accepted, together with all of
// its state updates. Amplitudes come from a constant table indexed by the level.
// Registers: 0x0 refresh period (ms), 0x4 default duration (ms), 0x8 maximum
// duration (ms); write them only while the block is idle.
module timed_rumble_refresh_controller
  import trrc_pkg::*;
#(
  parameter int unsigned MAX_LEVEL = 30
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  trrc_in_if.sink               in_i,
  trrc_out_if.source            out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned TabN = 2 ** (LevelW - 1);

  amp_t amp_tab [TabN];

  for (genvar i = 0; i < TabN; i++) begin : g_tab
    localparam int unsigned Amp = (i == 0) ? 0 :
                                  (i >= MAX_LEVEL) ? 65535 :
                                  ((i * 65535) + MAX_LEVEL / 2) / MAX_LEVEL;
    assign amp_tab[i] = AmpW'(Amp);
  end

  period_t refresh_q;
  dur_t    default_q;
  dur_t    max_q;

  logic    motor_active_q, motor_active_d;
  logic    stop_request_q, stop_request_d;
  amp_t    low_store_q, low_store_d;
  amp_t    high_store_q, high_store_d;
  dur_t    time_left_q, time_left_d;
  period_t wait_left_q, wait_left_d;
  logic    waiting_q, waiting_d;
  logic    renewed_q, renewed_d;

  logic    out_valid_q;
  logic    send_q, send_d;
  amp_t    lo_q, lo_d;
  amp_t    hi_q, hi_d;
  logic    acc_q, acc_d;

  logic    in_fire;
  logic    cfg_wr;
  amp_t    l_amp, h_amp;
  dur_t    dur;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      RegRefresh: prdata = DataW'(refresh_q);
      RegDefault: prdata = DataW'(default_q);
      RegMax:     prdata = DataW'(max_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_q <= RefreshReset;
      default_q <= DefaultReset;
      max_q     <= MaxReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegRefresh: refresh_q <= pwdata[PeriodW-1:0];
        RegDefault: default_q <= pwdata[DurW-1:0];
        RegMax:     max_q     <= pwdata[DurW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign l_amp = in_i.left_level[LevelW-1]  ? '0 : amp_tab[in_i.left_level[LevelW-2:0]];
  assign h_amp = in_i.right_level[LevelW-1] ? '0 : amp_tab[in_i.right_level[LevelW-2:0]];

  always_comb begin
    priority if (in_i.rumble_ms == '0) begin
      dur = default_q;
    end else if (in_i.rumble_ms > max_q) begin
      dur = max_q;
    end else begin
      dur = in_i.rumble_ms;
    end
  end

  always_comb begin
    motor_active_d = motor_active_q;
    stop_request_d = stop_request_q;
    low_store_d    = low_store_q;
    high_store_d   = high_store_q;
    time_left_d    = time_left_q;
    wait_left_d    = wait_left_q;
    waiting_d      = waiting_q;
    renewed_d      = renewed_q;
    send_d         = 1'b0;
    lo_d           = '0;
    hi_d           = '0;
    acc_d          = 1'b0;
    if (in_i.kind == KindCommand) begin
      if (in_i.ctrl_id == '0) begin
        acc_d        = 1'b1;
        low_store_d  = l_amp;
        high_store_d = h_amp;
        if (l_amp == '0 && h_amp == '0) begin
          motor_active_d = 1'b0;
          stop_request_d = 1'b1;
        end else begin
          motor_active_d = 1'b1;
          stop_request_d = 1'b0;
          time_left_d    = dur;
          renewed_d      = 1'b1;
        end
      end
    end else begin
      if (time_left_q != '0) begin
        time_left_d = time_left_q - DurW'(1);
      end
      if (waiting_q) begin
        if (wait_left_q != '0) begin
          wait_left_d = wait_left_q - PeriodW'(1);
        end
        if (wait_left_d == '0) begin
          waiting_d = 1'b0;
          if (motor_active_q && time_left_d == '0 && !renewed_q) begin
            motor_active_d = 1'b0;
            stop_request_d = 1'b1;
          end
        end
      end
      if (!waiting_d) begin
        priority if (stop_request_d) begin
          stop_request_d = 1'b0;
          send_d         = 1'b1;
        end else if (motor_active_d) begin
          send_d      = 1'b1;
          lo_d        = low_store_q;
          hi_d        = high_store_q;
          renewed_d   = 1'b0;
          wait_left_d = (refresh_q == '0) ? PeriodW'(1) : refresh_q;
          waiting_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_active_q <= 1'b0;
      stop_request_q <= 1'b0;
      low_store_q    <= '0;
      high_store_q   <= '0;
      time_left_q    <= '0;
      wait_left_q    <= '0;
      waiting_q      <= 1'b0;
      renewed_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        motor_active_q <= motor_active_d;
        stop_request_q <= stop_request_d;
        low_store_q    <= low_store_d;
        high_store_q   <= high_store_d;
        time_left_q    <= time_left_d;
        wait_left_q    <= wait_left_d;
        waiting_q      <= waiting_d;
        renewed_q      <= renewed_d;
        out_valid_q    <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      send_q <= send_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      acc_q  <= acc_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.report_sent      = send_q;
  assign out_o.low_amplitude    = lo_q;
  assign out_o.high_amplitude   = hi_q;
  assign out_o.command_accepted = acc_q;

endmodule
`default_nettype wire
